// File: rtl/core/stc_pkg.sv
// Shared types and constants of the spline transfer colormap.
package stc_pkg;

    localparam int NUM_POINTS  = 14;
    localparam int POINT_W     = 16;
    localparam int DIV_STEPS   = 20;   // 4 integer quotient bits, 16 fraction bits
    localparam int INT_STEPS   = 4;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES  = DIV_STEPS / STEPS_PER_STAGE;
    localparam int REM_W       = 37;
    localparam int DEN_W       = 32;
    localparam int T_W         = 20;

    localparam logic [T_W-1:0] T_FULL = 20'hA0000;   // ten in Q.16

    localparam logic [31:0] LOW_BOUND_RST    = 32'h0000_0000;
    localparam logic [31:0] HIGH_BOUND_RST   = 32'h0001_0000;
    localparam logic [47:0] GAINS_RST        = 48'h9C28_EB85_4A3D;

    typedef enum logic [2:0] {
        REG_LOW_BOUND   = 3'd0,
        REG_HIGH_BOUND  = 3'd1,
        REG_GAINS       = 3'd2,
        REG_POINTS_0    = 3'd3,
        REG_POINTS_3    = 3'd4,
        REG_POINTS_6    = 3'd5,
        REG_POINTS_9    = 3'd6,
        REG_POINTS_12   = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_ZERO = 2'd0,
        MODE_FULL = 2'd1,
        MODE_DIV  = 2'd2
    } stc_mode_t;

    typedef struct packed {
        logic      valid;
        logic      last;
        stc_mode_t mode;
    } stc_side_t;

    // One restoring step. Integer steps compare against the shifted
    // divisor; fraction steps double the remainder first.
    function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] r,
                                                input logic [DEN_W-1:0] d,
                                                input int j);
        logic [REM_W-1:0] rr;
        logic [REM_W-1:0] ds;
        if (j < INT_STEPS) begin
            rr = r;
            ds = {{(REM_W-DEN_W){1'b0}}, d} << (INT_STEPS - 1 - j);
        end else begin
            rr = r << 1;
            ds = {{(REM_W-DEN_W){1'b0}}, d};
        end
        if (rr >= ds) begin
            return {1'b1, rr - ds};
        end
        return {1'b0, rr};
    endfunction

endpackage

// File: rtl/core/stc_divider.sv
// Pipelined restoring divider, two quotient bits per stage.
module stc_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  stc_pkg::stc_side_t            side_in,
    input  logic [stc_pkg::REM_W-1:0]     rem_in,
    input  logic [stc_pkg::DEN_W-1:0]     den_in,
    output stc_pkg::stc_side_t            side_out,
    output logic [stc_pkg::T_W-1:0]       quo_out
);

    localparam int NS = stc_pkg::DIV_STAGES;

    stc_pkg::stc_side_t              side_reg [NS];
    logic [stc_pkg::REM_W-1:0]       rem_reg  [NS];
    logic [stc_pkg::DEN_W-1:0]       den_reg  [NS];
    logic [stc_pkg::T_W-1:0]         quo_reg  [NS];

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_stage
            stc_pkg::stc_side_t          side_prev;
            logic [stc_pkg::REM_W-1:0]   rem_prev;
            logic [stc_pkg::DEN_W-1:0]   den_prev;
            logic [stc_pkg::T_W-1:0]     quo_prev;
            logic [stc_pkg::REM_W-1:0]   rem_next;
            logic [stc_pkg::T_W-1:0]     quo_next;

            if (g == 0) begin : g_first
                assign side_prev = side_in;
                assign rem_prev  = rem_in;
                assign den_prev  = den_in;
                assign quo_prev  = '0;
            end else begin : g_rest
                assign side_prev = side_reg[g-1];
                assign rem_prev  = rem_reg[g-1];
                assign den_prev  = den_reg[g-1];
                assign quo_prev  = quo_reg[g-1];
            end

            always_comb begin
                logic [stc_pkg::REM_W:0] res;
                rem_next = rem_prev;
                quo_next = quo_prev;
                for (int k = 0; k < stc_pkg::STEPS_PER_STAGE; k++) begin
                    res = stc_pkg::div_step(rem_next, den_prev,
                                            g * stc_pkg::STEPS_PER_STAGE + k);
                    rem_next = res[stc_pkg::REM_W-1:0];
                    quo_next = {quo_next[stc_pkg::T_W-2:0], res[stc_pkg::REM_W]};
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    side_reg[g].valid <= 1'b0;
                end else if (en) begin
                    side_reg[g] <= side_prev;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[g] <= rem_next;
                    den_reg[g] <= den_prev;
                    quo_reg[g] <= quo_next;
                end
            end
        end
    endgenerate

    assign side_out = side_reg[NS-1];
    assign quo_out  = quo_reg[NS-1];

endmodule

// File: rtl/core/spline_transfer_colormap_unit.sv
// Top level of the spline transfer colormap pipeline.
//
// Energy samples (Q16.16) enter on the s_ stream, one beat each, with tlast
// marking the last pixel of a frame. Each beat yields one RGB beat on the
// m_ stream, tlast copied through. The bounds, channel gains and fourteen
// control points sit in write-only registers on the cfg_ port; write them
// only while the pipeline is empty.
// Throughput is one beat per cycle unless stalled. Stages: one stage for the
// magnitude and bound compare, one for the scaled dividend, ten for the
// 20-bit quotient (two restoring steps per stage), then point selection,
// three Horner multiply stages, the gain multiply and the byte scaling.
// All stages advance together; when m_tready is low with a beat waiting,
// the whole pipeline holds and s_tready drops, so nothing is lost.
// Reset clears every valid bit and loads the register defaults: bounds
// 0 and 1.0, gains 0.29/0.92/0.61, control points zero.
module spline_transfer_colormap_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [47:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] energy_sample
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] red, [15:8] green, [23:16] blue
    output logic        m_tlast
);

    // configuration
    logic [31:0] low_bound_reg;
    logic [31:0] high_bound_reg;
    logic [47:0] gains_reg;
    logic [47:0] pts0_reg, pts3_reg, pts6_reg, pts9_reg;
    logic [31:0] pts12_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_bound_reg  <= stc_pkg::LOW_BOUND_RST;
            high_bound_reg <= stc_pkg::HIGH_BOUND_RST;
            gains_reg      <= stc_pkg::GAINS_RST;
            pts0_reg       <= '0;
            pts3_reg       <= '0;
            pts6_reg       <= '0;
            pts9_reg       <= '0;
            pts12_reg      <= '0;
        end else if (cfg_we) begin
            unique case (stc_pkg::cfg_idx_t'(cfg_addr))
                stc_pkg::REG_LOW_BOUND:  low_bound_reg  <= cfg_wdata[31:0];
                stc_pkg::REG_HIGH_BOUND: high_bound_reg <= cfg_wdata[31:0];
                stc_pkg::REG_GAINS:      gains_reg      <= cfg_wdata;
                stc_pkg::REG_POINTS_0:   pts0_reg       <= cfg_wdata;
                stc_pkg::REG_POINTS_3:   pts3_reg       <= cfg_wdata;
                stc_pkg::REG_POINTS_6:   pts6_reg       <= cfg_wdata;
                stc_pkg::REG_POINTS_9:   pts9_reg       <= cfg_wdata;
                stc_pkg::REG_POINTS_12:  pts12_reg      <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage 1: magnitude minus one, bound compare
    logic signed [33:0] s_ext, abs_v, m_v, lo_v, hi_v, dnum, dden;
    stc_pkg::stc_mode_t mode_c;

    always_comb begin
        s_ext = {{2{s_tdata[31]}}, s_tdata};
        abs_v = s_tdata[31] ? -s_ext : s_ext;
        m_v   = abs_v - 34'sd65536;
        lo_v  = {{2{low_bound_reg[31]}}, low_bound_reg};
        hi_v  = {{2{high_bound_reg[31]}}, high_bound_reg};
        dnum  = m_v - lo_v;
        dden  = hi_v - lo_v;
        if (m_v <= lo_v) begin
            mode_c = stc_pkg::MODE_ZERO;
        end else if (m_v >= hi_v) begin
            mode_c = stc_pkg::MODE_FULL;
        end else begin
            mode_c = stc_pkg::MODE_DIV;
        end
    end

    stc_pkg::stc_side_t side1_reg, side2_reg;
    logic [31:0] d1_reg, den1_reg, den2_reg;
    logic [stc_pkg::REM_W-1:0] r2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side1_reg.valid <= 1'b0;
            side2_reg.valid <= 1'b0;
        end else if (en) begin
            side1_reg <= '{valid: s_tvalid, last: s_tlast, mode: mode_c};
            side2_reg <= side1_reg;
        end
    end

    // stage 2: dividend times ten
    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg   <= dnum[31:0];
            den1_reg <= dden[31:0];
            r2_reg   <= {4'b0, d1_reg, 1'b0} + {2'b0, d1_reg, 3'b0};
            den2_reg <= den1_reg;
        end
    end

    stc_pkg::stc_side_t side_d;
    logic [stc_pkg::T_W-1:0] quo_d;

    stc_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .side_in  (side2_reg),
        .rem_in   (r2_reg),
        .den_in   (den2_reg),
        .side_out (side_d),
        .quo_out  (quo_d)
    );

    // stage 3: pick four points, form the cubic coefficients
    logic [stc_pkg::POINT_W-1:0] pts [16];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pts[k]     = pts0_reg[16*k +: 16];
            pts[k + 3] = pts3_reg[16*k +: 16];
            pts[k + 6] = pts6_reg[16*k +: 16];
            pts[k + 9] = pts9_reg[16*k +: 16];
        end
        pts[12] = pts12_reg[15:0];
        pts[13] = pts12_reg[31:16];
        pts[14] = '0;
        pts[15] = '0;
    end

    logic [stc_pkg::T_W-1:0] t_v;
    logic [3:0] base;
    logic signed [19:0] p0e, p1e, p2e, p3e, a3_c, a2_c, a1_c;
    logic [15:0] p0, p1, p2, p3;

    always_comb begin
        case (side_d.mode)
            stc_pkg::MODE_ZERO: t_v = '0;
            stc_pkg::MODE_FULL: t_v = stc_pkg::T_FULL;
            default:            t_v = quo_d;
        endcase
        base = t_v[19:16];
        p0   = pts[base];
        p1   = pts[base + 4'd1];
        p2   = pts[base + 4'd2];
        p3   = pts[base + 4'd3];
        p0e  = {{4{p0[15]}}, p0};
        p1e  = {{4{p1[15]}}, p1};
        p2e  = {{4{p2[15]}}, p2};
        p3e  = {{4{p3[15]}}, p3};
        a3_c = p1e - p0e + (p1e <<< 1) - (p2e <<< 1) - p2e + p3e;
        a2_c = (p0e <<< 1) - (p1e <<< 2) - p1e + (p2e <<< 2) - p3e;
        a1_c = p2e - p0e;
    end

    stc_pkg::stc_side_t side3_reg, side4_reg, side5_reg, side6_reg, side7_reg;
    logic signed [19:0] a3_3_reg, a2_3_reg, a1_3_reg, a1_4_reg;
    logic [15:0] p1_3_reg, p1_4_reg, p1_5_reg;
    logic [15:0] f3_reg, f4_reg, f5_reg;
    logic signed [36:0] acc1_reg;
    logic signed [38:0] acc2_reg;
    logic signed [39:0] acc3_reg;
    logic [45:0] prod_r_reg, prod_g_reg, prod_b_reg;

    logic signed [36:0] mul4;
    logic signed [53:0] mul5;
    logic signed [55:0] mul6;
    logic signed [38:0] acc2_c;
    logic signed [39:0] acc3_c;
    logic [29:0] clamp_c;
    logic [53:0] sr, sg, sb;

    always_comb begin
        mul4   = a3_3_reg * $signed({1'b0, f3_reg});
        mul5   = acc1_reg * $signed({1'b0, f4_reg});
        acc2_c = 39'(mul5 >>> 16) + {{3{a1_4_reg[19]}}, a1_4_reg, 16'b0};
        mul6   = acc2_reg * $signed({1'b0, f5_reg});
        acc3_c = 40'(mul6 >>> 16) + {{7{p1_5_reg[15]}}, p1_5_reg, 17'b0};
        if (acc3_reg < 40'sd0) begin
            clamp_c = '0;
        end else if (acc3_reg > 40'sd536870912) begin
            clamp_c = 30'd536870912;
        end else begin
            clamp_c = acc3_reg[29:0];
        end
        // times 255 as (x << 8) - x
        sr = {prod_r_reg, 8'b0} - {8'b0, prod_r_reg};
        sg = {prod_g_reg, 8'b0} - {8'b0, prod_g_reg};
        sb = {prod_b_reg, 8'b0} - {8'b0, prod_b_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side3_reg.valid <= 1'b0;
            side4_reg.valid <= 1'b0;
            side5_reg.valid <= 1'b0;
            side6_reg.valid <= 1'b0;
            side7_reg.valid <= 1'b0;
            m_tvalid        <= 1'b0;
        end else if (en) begin
            side3_reg <= side_d;
            side4_reg <= side3_reg;
            side5_reg <= side4_reg;
            side6_reg <= side5_reg;
            side7_reg <= side6_reg;
            m_tvalid  <= side7_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a3_3_reg   <= a3_c;
            a2_3_reg   <= a2_c;
            a1_3_reg   <= a1_c;
            p1_3_reg   <= p1;
            f3_reg     <= t_v[15:0];
            acc1_reg   <= mul4 + {a2_3_reg[19], a2_3_reg, 16'b0};
            a1_4_reg   <= a1_3_reg;
            p1_4_reg   <= p1_3_reg;
            f4_reg     <= f3_reg;
            acc2_reg   <= acc2_c;
            p1_5_reg   <= p1_4_reg;
            f5_reg     <= f4_reg;
            acc3_reg   <= acc3_c;
            prod_r_reg <= clamp_c * gains_reg[15:0];
            prod_g_reg <= clamp_c * gains_reg[31:16];
            prod_b_reg <= clamp_c * gains_reg[47:32];
            m_tdata    <= {sb[52:45], sg[52:45], sr[52:45]};
            m_tlast    <= side7_reg.last;
        end
    end

`ifndef ASSERT_OFF
    a_div_range: assert property (@(posedge aclk) disable iff (!aresetn)
        side_d.valid && side_d.mode == stc_pkg::MODE_DIV |-> quo_d < stc_pkg::T_FULL)
        else $error("quotient out of range");
    a_div_order: assert property (@(posedge aclk) disable iff (!aresetn)
        side1_reg.valid && side1_reg.mode == stc_pkg::MODE_DIV |-> d1_reg < den1_reg)
        else $error("dividend not below divisor");
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(side7_reg) && $stable(acc3_reg))
        else $error("pipeline moved during stall");
`endif

endmodule

// File: tb/sv/tb_spline_transfer_colormap_unit.sv
// Self-checking testbench for the spline transfer colormap unit.
module tb_spline_transfer_colormap_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] sample;
        logic        last;
    } sample_beat_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pixel_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_addr = '0;
    logic [47:0] cfg_wdata = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    spline_transfer_colormap_unit DUT (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // predictor copy of the registers
    logic signed [31:0] lo_q;
    logic signed [31:0] hi_q;
    logic [47:0]        gains_q;
    logic [15:0]        ctrl_pts [stc_pkg::NUM_POINTS];

    sample_beat_t pending_samples [$];
    pixel_t       expected_pixels [$];
    int  errors = 0;
    int  pixels_seen = 0;
    int  cycles = 0;
    bit  hold_sender = 0;
    bit  hold_request = 0;
    bit  hold_started = 0;
    int  hold_off_cycles = 0;

    function automatic longint fl16(longint x);
        return x >>> 16;
    endfunction

    function automatic longint pt(int idx);
        if (idx >= stc_pkg::NUM_POINTS) return 0;
        return longint'($signed(ctrl_pts[idx]));
    endfunction

    function automatic pixel_t map_sample(sample_beat_t b);
        pixel_t r;
        longint s, m, t, f, p0, p1, p2, p3, a3, a2, a1, acc, g;
        int i;
        s = longint'($signed(b.sample));
        m = (s < 0 ? -s : s) - 65536;
        if (m <= lo_q) t = 0;
        else if (m >= hi_q) t = 655360;
        else t = ((m - lo_q) * 655360) / (longint'(hi_q) - longint'(lo_q));
        i = 1 + int'(t >> 16);
        f = t & 64'hFFFF;
        p0 = pt(i - 1); p1 = pt(i); p2 = pt(i + 1); p3 = pt(i + 2);
        a3 = -p0 + 3 * p1 - 3 * p2 + p3;
        a2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        a1 = p2 - p0;
        acc = a3 * 65536;
        acc = fl16(acc * f) + a2 * 65536;
        acc = fl16(acc * f) + a1 * 65536;
        acc = fl16(acc * f) + 2 * p1 * 65536;
        if (acc < 0) acc = 0;
        if (acc > (64'sd1 <<< 29)) acc = 64'sd1 <<< 29;
        g = gains_q[15:0];  r.red   = 8'((acc * g * 255) >> 45);
        g = gains_q[31:16]; r.green = 8'((acc * g * 255) >> 45);
        g = gains_q[47:32]; r.blue  = 8'((acc * g * 255) >> 45);
        r.last = b.last;
        return r;
    endfunction

    task automatic write_reg(stc_pkg::cfg_idx_t idx, logic [47:0] val);
        @(posedge aclk);
        cfg_we    <= 1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        case (idx)
            stc_pkg::REG_LOW_BOUND:  lo_q = val[31:0];
            stc_pkg::REG_HIGH_BOUND: hi_q = val[31:0];
            stc_pkg::REG_GAINS:      gains_q = val;
            stc_pkg::REG_POINTS_12: begin
                ctrl_pts[12] = val[15:0];
                ctrl_pts[13] = val[31:16];
            end
            default: begin
                for (int k = 0; k < 3; k++)
                    ctrl_pts[(int'(idx) - 3) * 3 + k] = val[16 * k +: 16];
            end
        endcase
    endtask

    task automatic wait_idle();
        wait (pending_samples.size() == 0 && expected_pixels.size() == 0);
        repeat (25) @(posedge aclk);
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic logic [31:0] rand_sample(logic signed [31:0] l,
                                                logic signed [31:0] h);
        longint span, v;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
            default: begin
                // land mostly inside the bounds so every segment is exercised
                span = longint'(h) - longint'(l);
                if (span <= 0) span = 65536;
                v = longint'(l) + 65536 + longint'({$urandom, $urandom} % (span + 2));
                if (v > 32'sh7fffffff) v = 32'sh7fffffff;
                if (v < 0) v = 0;
                return $urandom_range(0, 1) ? 32'(v) : 32'(-v);
            end
        endcase
    endfunction

    task automatic push_sample(logic [31:0] s, logic l);
        sample_beat_t b;
        b.sample = s;
        b.last = l;
        pending_samples.push_back(b);
    endtask

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_pixels.push_back(map_sample(pending_samples.pop_front()));
            end
            if (s_tvalid && !s_tready) begin
                // keep offering the same beat
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 0;
            end else begin
                if (pending_samples.size() > 0 && !hold_sender) begin
                    s_tvalid <= 1;
                    s_tdata  <= pending_samples[0].sample;
                    s_tlast  <= pending_samples[0].last;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // receiver stall pattern plus long hold-off
    logic [15:0] stall_pat = 16'hffff;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_request && !hold_started) begin
                hold_started    <= 1;
                hold_off_cycles <= 300;
                m_tready        <= 0;
            end else if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_tready <= 0;
            end else begin
                if ($urandom_range(0, 63) == 0)
                    stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
                else
                    stall_pat <= {stall_pat[14:0], stall_pat[15]};
                m_tready <= stall_pat[0];
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            automatic pixel_t got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast};
            pixels_seen <= pixels_seen + 1;
            if (expected_pixels.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected pixel %h", got);
            end else begin
                automatic pixel_t exp_px = expected_pixels.pop_front();
                if (got !== exp_px) begin
                    errors++;
                    if (errors <= 10)
                        $display("pixel mismatch: exp r%0d g%0d b%0d l%0d got r%0d g%0d b%0d l%0d",
                                 exp_px.red, exp_px.green, exp_px.blue, exp_px.last,
                                 got.red, got.green, got.blue, got.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("timeout with %0d pixels outstanding", expected_pixels.size());
            $display("spline_transfer_colormap_unit regression: fail");
            $finish;
        end
    end

    task automatic load_points(logic [15:0] p [stc_pkg::NUM_POINTS]);
        write_reg(stc_pkg::REG_POINTS_0, {p[2], p[1], p[0]});
        write_reg(stc_pkg::REG_POINTS_3, {p[5], p[4], p[3]});
        write_reg(stc_pkg::REG_POINTS_6, {p[8], p[7], p[6]});
        write_reg(stc_pkg::REG_POINTS_9, {p[11], p[10], p[9]});
        write_reg(stc_pkg::REG_POINTS_12, {16'h0, p[13], p[12]});
    endtask

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++)
            push_sample(rand_sample(lo_q, hi_q), ($urandom_range(0, 15) == 0));
    endtask

    initial begin
        logic [15:0] pts [stc_pkg::NUM_POINTS];
        lo_q = stc_pkg::LOW_BOUND_RST;
        hi_q = stc_pkg::HIGH_BOUND_RST;
        gains_q = stc_pkg::GAINS_RST;
        foreach (ctrl_pts[k]) ctrl_pts[k] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;

        // directed: a rising curve with overshoot, reset bounds and gains
        foreach (pts[k]) pts[k] = 16'(k * 410 - 600);
        pts[6] = 16'h7fff;
        pts[7] = 16'h8000;
        load_points(pts);
        push_sample(32'h0, 0);
        push_sample(32'h8000_0000, 1);
        push_sample(32'h7fff_ffff, 0);
        push_sample(32'h0001_0000, 0);
        push_sample(32'hffff_0000, 0);
        push_sample(32'h0001_8000, 1);
        push_sample(32'hfffe_8000, 0);
        push_sample(32'h0001_0001, 0);
        push_sample(32'h0001_ffff, 1);
        push_sample(32'h0002_0000, 0);
        push_sample(32'h0002_0001, 0);
        for (int k = 0; k < 10; k++) push_sample(32'h0001_0000 + k * 6554 + 3, k[0]);
        wait_idle();

        // bounds unordered; full gains; extreme bounds
        write_reg(stc_pkg::REG_LOW_BOUND, 48'h0000_0002_0000);
        write_reg(stc_pkg::REG_HIGH_BOUND, 48'h0000_0001_0000);
        write_reg(stc_pkg::REG_GAINS, 48'hffff_ffff_ffff);
        push_sample(32'h0003_0000, 1);
        push_sample(32'h0002_0000, 0);
        push_sample(32'h0000_8000, 0);
        wait_idle();
        write_reg(stc_pkg::REG_LOW_BOUND, 48'h0000_8000_0000);
        write_reg(stc_pkg::REG_HIGH_BOUND, 48'h0000_7fff_ffff);
        random_phase(150);

        // long receiver hold-off so the pipeline backs up
        wait (pending_samples.size() < 100);
        hold_request = 1;
        wait_idle();

        for (int ph = 0; ph < 5; ph++) begin
            logic signed [31:0] a, b;
            foreach (pts[k]) pts[k] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                     : 16'($urandom_range(0, 5000));
            load_points(pts);
            write_reg(stc_pkg::REG_GAINS, (ph == 4) ? 48'h0 : rand48());
            a = $signed(32'($urandom_range(0, 5 << 16))) - 32'sd65536;
            b = a + $signed(32'($urandom_range(1, 8 << 16)));
            if (ph == 3) b = a - 1;
            write_reg(stc_pkg::REG_LOW_BOUND, {16'h0, a});
            write_reg(stc_pkg::REG_HIGH_BOUND, {16'h0, b});
            random_phase(140);
            // sender pauses mid-phase until everything has drained
            if (ph == 2) begin
                wait (pending_samples.size() < 70);
                hold_sender = 1;
                wait (!s_tvalid && expected_pixels.size() == 0);
                repeat (10) @(posedge aclk);
                hold_sender = 0;
            end
            wait_idle();
        end

        wait_idle();
        $display("covered clamp/division/unordered-bound cases, saturation, stalls and hold-off;");
        $display("%0d pixels checked across several bound, gain and control point settings",
                 pixels_seen);
        if (errors == 0 && expected_pixels.size() == 0) begin
            $display("spline_transfer_colormap_unit regression: pass");
        end else begin
            $display("spline_transfer_colormap_unit regression: fail");
        end
        $finish;
    end
endmodule
